@@ hdl/wbps_pkg.sv @@
// Package for the wildcard byte pattern scanner: register indexes, widths and defaults.
package wbps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 48;
   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam int PATTERN_REG_COUNT = 6;
   localparam int PATTERN_REG_W     = 64;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int MASK_W            = 48;
   localparam int LENGTH_W          = 6;
   localparam int BYTE_W            = 8;
   localparam int MATCH_OFFSET_W    = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_0  = 3'd0,
      CSR_PATTERN_1  = 3'd1,
      CSR_PATTERN_2  = 3'd2,
      CSR_PATTERN_3  = 3'd3,
      CSR_PATTERN_4  = 3'd4,
      CSR_PATTERN_5  = 3'd5,
      CSR_WILDCARD   = 3'd6,
      CSR_LENGTH     = 3'd7
   } csr_index_type;

endpackage

@@ hdl/wildcard_byte_pattern_scanner_unit.sv @@
// Wildcard byte pattern scanner: sliding-window compare of a byte stream against a masked pattern.
//
// Usage
//   req_*  : one image byte per beat, req_last_byte marks the final byte of an image.
//   rsp_*  : at most one beat per image. rsp_found=1 with rsp_match_offset giving the
//            start offset of the first match, or rsp_found=0 (offset 0) when the image
//            ended without a match. A match on the last byte gives only the found beat.
//   csr_*  : register writes, csr_ready is always high. Index 0..5 pattern bytes
//            (eight per register, byte 0 in the low bits), 6 wildcard mask, 7 length.
//            Write only while the block is idle.
// Timing
//   One byte per cycle sustained while no result is blocked. A byte is shifted into the
//   window register at acceptance, compared against the pre-aligned pattern in the next
//   cycle, and its result (if any) moves on into the output register when that register is free.
//   The compare stage is the single slot that holds an item; it only blocks the input
//   when it carries a result and the output register is full and stalled.
// Reset
//   Synchronous, active high. Pattern 0, mask 0, length 1, empty pipeline, byte count 0.
//   Once the last byte of an image leaves the compare stage the byte count and the
//   match flag clear, so the following byte starts a new image.
module wildcard_byte_pattern_scanner_unit
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // byte input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [wbps_pkg::BYTE_W-1:0]            req_data_byte,
   input  logic                                   req_last_byte,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [wbps_pkg::MATCH_OFFSET_W-1:0]    rsp_match_offset,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

   // ---------------- configuration registers ----------------
   logic [PATTERN_REG_COUNT-1:0][PATTERN_REG_W-1:0] pattern_ff;
   logic [MASK_W-1:0]                               mask_ff;
   logic [LENGTH_W-1:0]                             length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         mask_ff    <= '0;
         length_ff  <= LENGTH_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_0, CSR_PATTERN_1, CSR_PATTERN_2,
            CSR_PATTERN_3, CSR_PATTERN_4, CSR_PATTERN_5: begin
               pattern_ff[csr_index] <= csr_data;
            end
            CSR_WILDCARD: begin
               mask_ff <= csr_data[MASK_W-1:0];
            end
            CSR_LENGTH: begin
               length_ff <= csr_data[LENGTH_W-1:0];
            end
            default: begin
               mask_ff <= mask_ff;
            end
         endcase
      end
   end

   // ---------------- pattern alignment ----------------
   // Window slot j (0 = newest) meets pattern byte len-1-j. The aligned copy is
   // registered off the config registers so the per-byte path is a plain compare.
   logic [PATTERN_REG_COUNT*PATTERN_REG_W/BYTE_W-1:0][BYTE_W-1:0] pat_bytes;
   logic [LEN_W-1:0]                           eff_len_in, eff_len_ff;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0]         aligned_pat_in, aligned_pat_ff;
   logic [MAX_PATTERN-1:0]                     care_in, care_ff;

   assign pat_bytes = pattern_ff;

   always_comb begin
      if (length_ff == '0) begin
         eff_len_in = LEN_W'(1);
      end else if (length_ff > LENGTH_W'(MAX_PATTERN)) begin
         eff_len_in = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len_in = LEN_W'(length_ff);
      end
   end

   always_comb begin
      logic [LENGTH_W-1:0] pidx;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pidx = LENGTH_W'(int'(eff_len_in) - 1 - j);
         if (j < int'(eff_len_in)) begin
            aligned_pat_in[j] = pat_bytes[pidx];
            care_in[j]        = ~mask_ff[pidx];
         end else begin
            aligned_pat_in[j] = '0;
            care_in[j]        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff     <= LEN_W'(1);
         aligned_pat_ff <= '0;
         care_ff        <= MAX_PATTERN'(1);
      end else begin
         eff_len_ff     <= eff_len_in;
         aligned_pat_ff <= aligned_pat_in;
         care_ff        <= care_in;
      end
   end

   // ---------------- window, byte count, compare stage ----------------
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_ff;
   logic [OFFSET_BITS-1:0]             seen_ff, seen_in, seen_base;
   logic                               reported_ff, reported_in;
   logic                               s1_valid_ff, s1_valid_in;
   logic                               s1_last_ff, s1_last_in;

   logic                               req_accept;
   logic                               s1_done;
   logic                               s1_result;
   logic                               s1_hit;
   logic                               s1_found;
   logic                               out_free;
   logic [MAX_PATTERN-1:0]             slot_ok;
   logic [OFFSET_BITS-1:0]             start_diff;

   // unused slots (j >= len) have care cleared, so they pass
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         slot_ok[j] = ~care_ff[j] | (window_ff[j] == aligned_pat_ff[j]);
      end
   end

   assign s1_hit     = (&slot_ok) && (seen_ff >= OFFSET_BITS'(eff_len_ff));
   assign s1_found   = s1_valid_ff && !reported_ff && s1_hit;
   assign s1_result  = s1_found || (s1_valid_ff && s1_last_ff && !reported_ff);
   assign start_diff = seen_ff - OFFSET_BITS'(eff_len_ff);

   assign out_free   = !rsp_valid || !rsp_stall;
   assign s1_done    = s1_valid_ff && (!s1_result || out_free);
   assign req_stall  = s1_valid_ff && !s1_done;
   assign req_accept = req_valid && !req_stall;

   // a finished last byte restarts the count for whatever comes next
   assign seen_base = (s1_done && s1_last_ff) ? '0 : seen_ff;

   always_comb begin
      if (req_accept) begin
         seen_in = (seen_base == COUNT_MAX) ? seen_base : seen_base + OFFSET_BITS'(1);
      end else begin
         seen_in = seen_base;
      end

      // the match flag only sets once the found beat has left for the output register
      if (s1_done && s1_last_ff) begin
         reported_in = 1'b0;
      end else if (s1_done && s1_found) begin
         reported_in = 1'b1;
      end else begin
         reported_in = reported_ff;
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req_last_byte;
      end else begin
         s1_valid_in = s1_valid_ff && !s1_done;
         s1_last_in  = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   // window needs no clear: a compare only runs once len bytes of this image are in
   always_ff @(posedge clock) begin
      if (req_accept) begin
         window_ff[0] <= req_data_byte;
         for (int j = 1; j < MAX_PATTERN; j++) begin
            window_ff[j] <= window_ff[j-1];
         end
      end
   end

   // ---------------- output register ----------------
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [MATCH_OFFSET_W-1:0] rsp_offset_ff;
   logic                      rsp_load;

   assign rsp_load = s1_done && s1_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff  <= s1_found;
         rsp_offset_ff <= s1_found ? MATCH_OFFSET_W'(start_diff) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // ---------------- assertions ----------------
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_result && rsp_valid_ff))
      else $error("input stalled without a blocked result");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_offset == '0))
      else $error("not-found beat with nonzero offset");

   a_image_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_done && s1_last_ff && !req_accept) |=> (seen_ff == '0 && !reported_ff))
      else $error("scan state not cleared after last byte");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (eff_len_ff != '0) && (eff_len_ff <= LEN_W'(MAX_PATTERN)))
      else $error("effective length out of range");

   a_one_result_per_image: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && s1_found && !s1_last_ff) |=> reported_ff)
      else $error("match flag not set after found beat");

endmodule
